// ===== src/blg_pkg.sv =====
// Shared types, constants and helpers for the battery LED gauge.
// Used by blg_ring, blg_disp and battery_level_led_gauge_unit; no dependencies.
`timescale 1ns / 1ps

package blg_pkg;

  localparam int AVG_DEPTH   = 16;
  localparam int LED_COUNT   = 5;
  localparam int PTR_W       = $clog2(AVG_DEPTH);
  localparam int SUM_W       = 16 + PTR_W;
  localparam int LEVEL_STEPS = 10;
  localparam int MV_OFFSET   = 60;
  localparam int THR_BASE    = 20750;
  localparam int THR_STEP    = 500;
  localparam int PROD_W      = 36;

  typedef enum logic [2:0] {
    REG_ADC_GAIN,
    REG_DEBOUNCE,
    REG_DISPLAY,
    REG_STARTUP,
    REG_BLINK,
    REG_DEBUG
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] adc_sample;
    logic        button_level;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [LED_COUNT-1:0] led_vector;
    logic [3:0]           gauge_level;
    logic [15:0]          average_mv;
  } out_t;

  typedef struct packed {
    logic [23:0] adc_gain_q16;
    logic [15:0] debounce_ms;
    logic [23:0] display_ms;
    logic [23:0] startup_display_ms;
    logic [15:0] blink_period_ms;
    logic        debug_show;
  } cfg_t;

  typedef struct packed {
    logic [15:0] avg_mv;
    logic        button_level;
    logic [31:0] now_ms;
  } ring_out_t;

  function automatic logic [15:0] thr_mv(input int k);
    return 16'(THR_BASE + THR_STEP * k);
  endfunction

endpackage

// ===== src/blg_ring.sv =====
// Sample scaling and moving-average ring held in a synchronous memory.
// Depends on blg_pkg.
`timescale 1ns / 1ps

module blg_ring (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_fire,
  input  blg_pkg::in_t             in_data,
  input  logic [23:0]              gain,
  input  logic                     s1_move,
  output blg_pkg::ring_out_t       s2_data
);

  logic [blg_pkg::PROD_W-1:0] prod_r;
  logic [blg_pkg::PTR_W-1:0]  ptr_r, ptr_nxt, addr_r;
  logic                       btn_r;
  logic [31:0]                now_r;
  logic [15:0]                mem [blg_pkg::AVG_DEPTH];
  logic [blg_pkg::AVG_DEPTH-1:0] vld_r;
  logic [15:0]                rd_data_r;
  logic                       rd_vld_r;
  logic [blg_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [19:0]                q;
  logic [19:0]                diff;
  logic [15:0]                mv;
  logic [15:0]                old_mv;
  blg_pkg::ring_out_t         s2_r;

  assign ptr_nxt = (ptr_r == blg_pkg::PTR_W'(blg_pkg::AVG_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  assign q       = prod_r[blg_pkg::PROD_W-1:16];
  assign diff    = q - 20'(blg_pkg::MV_OFFSET);
  assign old_mv  = rd_vld_r ? rd_data_r : 16'd0;

  always_comb begin
    if (q <= 20'(blg_pkg::MV_OFFSET)) begin
      mv = 16'd0;
    end else if (diff > 20'd65535) begin
      mv = 16'hFFFF;
    end else begin
      mv = diff[15:0];
    end
  end

  assign sum_nxt = sum_r - blg_pkg::SUM_W'(old_mv) + blg_pkg::SUM_W'(mv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      vld_r <= '0;
      sum_r <= '0;
    end else begin
      if (in_fire) begin
        ptr_r <= ptr_nxt;
      end
      if (s1_move) begin
        vld_r[addr_r] <= 1'b1;
        sum_r         <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      mem[addr_r] <= mv;
    end
    if (in_fire) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prod_r   <= blg_pkg::PROD_W'(in_data.adc_sample) * blg_pkg::PROD_W'(gain);
      addr_r   <= ptr_r;
      btn_r    <= in_data.button_level;
      now_r    <= in_data.now_ms;
      rd_vld_r <= vld_r[ptr_r];
    end
    if (s1_move) begin
      s2_r.avg_mv       <= 16'(sum_nxt / blg_pkg::AVG_DEPTH);
      s2_r.button_level <= btn_r;
      s2_r.now_ms       <= now_r;
    end
  end

  assign s2_data = s2_r;

endmodule

// ===== src/blg_disp.sv =====
// Level quantiser, button debounce, display window and blink control.
// Depends on blg_pkg; drives the registered result beat.
`timescale 1ns / 1ps

module blg_disp (
  input  logic               clk,
  input  logic               rst_n,
  input  blg_pkg::cfg_t      cfg,
  input  blg_pkg::ring_out_t s2_data,
  input  logic               s2_move,
  output blg_pkg::out_t      out_data
);

  localparam logic [blg_pkg::LED_COUNT-1:0] LED_ALL = '1;

  logic [31:0] blink_last_r, blink_last_nxt;
  logic        phase_r, phase_nxt;
  logic        last_btn_r;
  logic [31:0] btn_chg_r, btn_chg_nxt;
  logic        disp_on_r, disp_on_nxt;
  logic        startup_r, startup_nxt;
  logic [31:0] start_r, start_nxt;
  logic [blg_pkg::LED_COUNT-1:0] hold_r, hold_nxt;
  logic [3:0]  level;
  logic [3:0]  full;
  logic [31:0] since;
  logic        shown;
  logic        fire;
  logic        chg;
  blg_pkg::out_t out_r;

  always_comb begin
    level = 4'd0;
    for (int k = 0; k < blg_pkg::LEVEL_STEPS; k++) begin
      if (s2_data.avg_mv > blg_pkg::thr_mv(k)) begin
        level = 4'(k + 1);
      end
    end
  end

  always_comb begin
    btn_chg_nxt    = btn_chg_r;
    disp_on_nxt    = disp_on_r;
    startup_nxt    = startup_r;
    start_nxt      = start_r;
    blink_last_nxt = blink_last_r;
    phase_nxt      = phase_r;
    hold_nxt       = hold_r;
    full           = level >> 1;

    chg = (s2_data.button_level != last_btn_r) &&
          ((s2_data.now_ms - btn_chg_r) > {16'd0, cfg.debounce_ms});
    if (chg) begin
      btn_chg_nxt = s2_data.now_ms;
      if (s2_data.button_level) begin
        disp_on_nxt = 1'b1;
        start_nxt   = s2_data.now_ms;
      end
    end

    since = s2_data.now_ms - start_nxt;
    shown = (startup_r && (since < {8'd0, cfg.startup_display_ms})) ||
            (disp_on_nxt && (since < {8'd0, cfg.display_ms})) ||
            (level == 4'd0) || cfg.debug_show;

    fire = shown && ((level == 4'd0) || level[0]) &&
           ((s2_data.now_ms - blink_last_r) >= {16'd0, cfg.blink_period_ms});
    if (fire) begin
      blink_last_nxt = s2_data.now_ms;
      phase_nxt      = ~phase_r;
    end

    if (!shown) begin
      hold_nxt    = '0;
      disp_on_nxt = 1'b0;
      startup_nxt = 1'b0;
    end else if (level == 4'd0) begin
      if (fire) begin
        hold_nxt = phase_nxt ? LED_ALL : '0;
      end
    end else begin
      for (int i = 0; i < blg_pkg::LED_COUNT; i++) begin
        if (4'(i) < full) begin
          hold_nxt[i] = 1'b1;
        end else if (4'(i) > full) begin
          hold_nxt[i] = 1'b0;
        end else if (!level[0]) begin
          hold_nxt[i] = 1'b0;
        end else if (fire) begin
          hold_nxt[i] = phase_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_last_r <= '0;
      phase_r      <= 1'b0;
      last_btn_r   <= 1'b0;
      btn_chg_r    <= '0;
      disp_on_r    <= 1'b1;
      startup_r    <= 1'b1;
      start_r      <= '0;
      hold_r       <= '0;
    end else if (s2_move) begin
      blink_last_r <= blink_last_nxt;
      phase_r      <= phase_nxt;
      last_btn_r   <= s2_data.button_level;
      btn_chg_r    <= btn_chg_nxt;
      disp_on_r    <= disp_on_nxt;
      startup_r    <= startup_nxt;
      start_r      <= start_nxt;
      hold_r       <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_r.led_vector  <= hold_nxt;
      out_r.gauge_level <= level;
      out_r.average_mv  <= s2_data.avg_mv;
    end
  end

  assign out_data = out_r;

endmodule

// ===== src/battery_level_led_gauge_unit.sv =====
// Top level of the battery LED gauge: configuration registers and beat control.
// Depends on blg_pkg, blg_ring and blg_disp.
//
// Usage:
//   Input beats (in_valid/in_ready/in_data) carry one tick: converter sample,
//   raw button level and millisecond timestamp. Every input beat yields exactly
//   one result beat (out_valid/out_ready/out_data): LED vector, half-LED level
//   and moving-average millivolts.
//   Stages: scale multiply and ring memory read, ring sum update, then
//   level/display/blink into the output register. Throughput: one beat per
//   cycle unless out_ready stalls, with the single-port-per-side ring memory
//   read at accept and written as the beat leaves the first stage.
//   Stalls: each stage holds its beat while the next is full; in_ready drops
//   only when all three stages hold beats and out_ready is low.
//   Reset (rst_n low, synchronous): ring entries read as zero via per-entry
//   valid bits cleared at once, no clearing pass; registers take their reset
//   values; the startup display window opens at timestamp zero.
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr at once; write
//   only while no beats are in flight.
`timescale 1ns / 1ps

module battery_level_led_gauge_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  blg_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output blg_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_addr,
  input  logic [23:0]    cfg_wdata
);

  blg_pkg::cfg_t      cfg_r;
  blg_pkg::ring_out_t s2_data;
  logic               s1_v_r, s2_v_r, out_v_r;
  logic               out_adv, s2_adv, s1_adv;
  logic               in_fire, s1_move, s2_move;

  assign out_adv  = !out_v_r || out_ready;
  assign s2_adv   = !s2_v_r || out_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign s1_move  = s1_v_r && s2_adv;
  assign s2_move  = s2_v_r && out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_fire;
      end
      if (s2_adv) begin
        s2_v_r <= s1_move;
      end
      if (out_adv) begin
        out_v_r <= s2_move;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adc_gain_q16       <= 24'd655360;
      cfg_r.debounce_ms        <= 16'd50;
      cfg_r.display_ms         <= 24'd10000;
      cfg_r.startup_display_ms <= 24'd15000;
      cfg_r.blink_period_ms    <= 16'd500;
      cfg_r.debug_show         <= 1'b0;
    end else if (cfg_we) begin
      case (blg_pkg::cfg_reg_t'(cfg_addr))
        blg_pkg::REG_ADC_GAIN: cfg_r.adc_gain_q16       <= cfg_wdata;
        blg_pkg::REG_DEBOUNCE: cfg_r.debounce_ms        <= cfg_wdata[15:0];
        blg_pkg::REG_DISPLAY:  cfg_r.display_ms         <= cfg_wdata;
        blg_pkg::REG_STARTUP:  cfg_r.startup_display_ms <= cfg_wdata;
        blg_pkg::REG_BLINK:    cfg_r.blink_period_ms    <= cfg_wdata[15:0];
        blg_pkg::REG_DEBUG:    cfg_r.debug_show         <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  blg_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .gain    (cfg_r.adc_gain_q16),
    .s1_move (s1_move),
    .s2_data (s2_data)
  );

  blg_disp u_disp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s2_data  (s2_data),
    .s2_move  (s2_move),
    .out_data (out_data)
  );

  assign out_valid = out_v_r;

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ready)
    else $error("in_ready low with empty output stage");

  a_s1_hands_on: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_v_r) |-> s1_move)
    else $error("beat accepted over a held first stage");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.gauge_level <= 4'd10))
    else $error("gauge level out of range");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !s2_move) |=> !out_valid)
    else $error("result beat repeated");

endmodule
